// File: src/ces_pkg.sv
// shared widths, reset values, register indexes and control structs for the chandelier exit block
package ces_pkg;

  // field and datapath widths
  localparam int PRICE_W    = 32;
  localparam int ATR_W      = 56;
  localparam int COEF_W     = 16;
  localparam int RECIP_W    = 17;
  localparam int PERIOD_W   = 7;
  localparam int OUT_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // shared multiplier: 32 x 17 product, 56 x 17 accumulated in two halves
  localparam int LO_W    = 24;
  localparam int MUL_A_W = ATR_W - LO_W;
  localparam int PROD_W  = MUL_A_W + RECIP_W;
  localparam int ACC_W   = ATR_W + RECIP_W;
  localparam int Q_SHIFT = 16;

  localparam logic [ATR_W-1:0] ATR_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP  = 2'd2;

  // register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 7'd22;
  localparam logic [COEF_W-1:0]   COEF_RST   = 16'd768;
  localparam logic [RECIP_W-1:0]  RECIP_RST  = 17'd2979;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mul_ctrl_t;

  typedef struct packed {
    logic push;
    logic clear;
  } win_ctrl_t;

endpackage

// File: src/chandelier_exit_stream.sv
// chandelier exit over a bar stream: window extremes less/plus a smoothed atr times a multiplier
// sequence per bar: push, scan, decrement multiply (mlo, mhi, madd), dec, tradd, offset multiply,
//   out; the scan step waits on the one-entry-per-cycle rescan of the ring store when an extreme
//   leaves the window; the bar that ends warm-up runs init in place of the decrement steps
// a new bar is taken only back at idle, once the previous bar's steps are done; other warm-up
//   bars stop after the scan; a held result stalls the sequence in out
// reset: synchronous rst restores registers and state; store entries read zero until written,
//   so no clearing pass is needed; a period write restarts the state the same way
module chandelier_exit_stream #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // bar request: high_price [31:0], low_price [63:32], close_price [95:64]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [3*ces_pkg::PRICE_W-1:0]     s_axis_tdata,
  // result request: exit_long [47:0], exit_short [95:48]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*ces_pkg::OUT_W-1:0]       m_axis_tdata,
  // register writes
  input  logic                              cfg_we,
  input  logic [ces_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ces_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W   = SLOT_W + 1;
  localparam int PRICE_W = ces_pkg::PRICE_W;
  localparam int ATR_W   = ces_pkg::ATR_W;
  localparam int ACC_W   = ces_pkg::ACC_W;
  localparam int PROD_W  = ces_pkg::PROD_W;
  localparam int MUL_A_W = ces_pkg::MUL_A_W;
  localparam int RECIP_W = ces_pkg::RECIP_W;
  localparam int OUT_W   = ces_pkg::OUT_W;
  localparam int LO_W    = ces_pkg::LO_W;
  localparam int DEC_W   = ACC_W - ces_pkg::Q_SHIFT;
  localparam int EXT_W   = OUT_W + 2;

  // signed output limits in the extended width
  localparam logic signed [EXT_W-1:0] OUT_HI = {{(EXT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] OUT_LO = {{(EXT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_MLO,
    S_MHI,
    S_MADD,
    S_DEC,
    S_TRADD,
    S_INIT,
    S_OUT
  } state_t;

  // what the product in the accumulator is for
  typedef enum logic [1:0] {
    JOB_DEC,
    JOB_INIT,
    JOB_OFF
  } job_t;

  state_t state;
  job_t   job;

  logic [ces_pkg::PERIOD_W-1:0] period_reg;
  logic [ces_pkg::COEF_W-1:0]   coef_reg;
  logic [RECIP_W-1:0]           recip_reg;

  logic [ATR_W-1:0]   atr;
  logic [PRICE_W-1:0] last_close, high_r, low_r, tr, tr_in;
  logic [CNT_W-1:0]   bars_seen, p;
  logic               warm;
  logic               out_valid;
  logic [OUT_W-1:0]   out_long, out_short;

  logic [PRICE_W-1:0] in_high, in_low, in_close, range_hl, gap_h, gap_l;
  logic [PRICE_W-1:0] max_val, min_val;
  logic               win_busy, period_wr, accept;

  logic [MUL_A_W-1:0] mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod, add_b;
  logic [ACC_W-1:0]   acc;
  logic [ATR_W:0]     add_sum;
  logic [ATR_W-1:0]   add_sat, init_sat, dec;
  logic [DEC_W-1:0]   scaled;
  logic [OUT_W-1:0]   off, long_sat, short_sat;
  logic signed [EXT_W-1:0] long_raw, short_raw;

  ces_pkg::mul_ctrl_t mul_ctrl;
  ces_pkg::win_ctrl_t win_ctrl;

  assign in_high  = s_axis_tdata[PRICE_W-1:0];
  assign in_low   = s_axis_tdata[2*PRICE_W-1:PRICE_W];
  assign in_close = s_axis_tdata[3*PRICE_W-1:2*PRICE_W];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign period_wr     = cfg_we && (cfg_index == ces_pkg::CFG_PERIOD);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_short, out_long};

  // effective period: zero acts as one, capped at the store depth
  always_comb begin
    if (period_reg == '0) begin
      p = CNT_W'(1);
    end else if (int'(period_reg) > WINDOW_MAX) begin
      p = CNT_W'(WINDOW_MAX);
    end else begin
      p = CNT_W'(period_reg);
    end
  end

  // true range; an inverted bar gives a zero high-low term, the first bar skips the gaps
  always_comb begin
    range_hl = (in_high >= in_low) ? in_high - in_low : '0;
    gap_h    = (in_high >= last_close) ? in_high - last_close : last_close - in_high;
    gap_l    = (in_low >= last_close) ? in_low - last_close : last_close - in_low;
    tr_in    = range_hl;
    if (bars_seen != '0) begin
      if (gap_h > tr_in) begin
        tr_in = gap_h;
      end
      if (gap_l > tr_in) begin
        tr_in = gap_l;
      end
    end
  end

  // one saturating adder for the warm-up sum and the smoothing step
  assign add_b   = (state == S_TRADD) ? prod : PROD_W'(tr);
  assign add_sum = {1'b0, atr} + (ATR_W + 1)'(add_b);
  assign add_sat = add_sum[ATR_W] ? ces_pkg::ATR_MAX : add_sum[ATR_W-1:0];

  // warm-up end: sum times reciprocal, saturated
  assign init_sat = (acc[ACC_W-1:ATR_W] != '0) ? ces_pkg::ATR_MAX : acc[ATR_W-1:0];

  // smoothing decrement floor(atr*recip/2^16), capped at atr
  assign scaled = acc[ACC_W-1:ces_pkg::Q_SHIFT];
  assign dec    = (scaled > DEC_W'(atr)) ? atr : scaled[ATR_W-1:0];

  // offset floor(coef*atr/2^24) and clamped exits
  assign off       = acc[LO_W+OUT_W-1:LO_W];
  assign long_raw  = EXT_W'(max_val) - EXT_W'(off);
  assign short_raw = EXT_W'(min_val) + EXT_W'(off);
  assign long_sat  = (long_raw > OUT_HI) ? OUT_HI[OUT_W-1:0] :
                     (long_raw < OUT_LO) ? OUT_LO[OUT_W-1:0] : long_raw[OUT_W-1:0];
  assign short_sat = (short_raw > OUT_HI) ? OUT_HI[OUT_W-1:0] :
                     (short_raw < OUT_LO) ? OUT_LO[OUT_W-1:0] : short_raw[OUT_W-1:0];

  // multiplier operands: low then high slice of atr, or the true range
  always_comb begin
    case (state)
      S_MLO:   mul_a = MUL_A_W'(atr[LO_W-1:0]);
      S_MHI:   mul_a = atr[ATR_W-1:LO_W];
      default: mul_a = tr;
    endcase
    mul_b = (job == JOB_OFF) ? RECIP_W'(coef_reg) : recip_reg;
  end

  always_comb begin
    mul_ctrl.mul_en = (state == S_MLO) || (state == S_MHI) || (state == S_DEC);
    case (state)
      S_MHI:   mul_ctrl.acc_op = ces_pkg::ACC_LOAD;
      S_MADD:  mul_ctrl.acc_op = ces_pkg::ACC_ADD_HI;
      default: mul_ctrl.acc_op = ces_pkg::ACC_HOLD;
    endcase
  end

  assign win_ctrl.push  = (state == S_PUSH);
  assign win_ctrl.clear = period_wr;

  ces_mul u_mul (
    .clk   (clk),
    .ctrl  (mul_ctrl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod),
    .acc   (acc)
  );

  ces_window #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (win_ctrl),
    .period  (p),
    .high    (high_r),
    .low     (low_r),
    .max_val (max_val),
    .min_val (min_val),
    .busy    (win_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      job        <= JOB_DEC;
      period_reg <= ces_pkg::PERIOD_RST;
      coef_reg   <= ces_pkg::COEF_RST;
      recip_reg  <= ces_pkg::RECIP_RST;
      atr        <= '0;
      last_close <= '0;
      bars_seen  <= '0;
      warm       <= 1'b0;
      high_r     <= '0;
      low_r      <= '0;
      tr         <= '0;
      out_valid  <= 1'b0;
      out_long   <= '0;
      out_short  <= '0;
    end else begin
      // a result taken while another waits in S_OUT is replaced there
      if (out_valid && m_axis_tready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            high_r     <= in_high;
            low_r      <= in_low;
            tr         <= tr_in;
            last_close <= in_close;
            warm       <= (bars_seen >= p);
            state      <= S_PUSH;
          end
        end
        S_PUSH: begin
          // warm-up: sum true ranges in whole ticks
          if (!warm) begin
            atr       <= add_sat;
            bars_seen <= bars_seen + CNT_W'(1);
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!win_busy) begin
            if (warm) begin
              job   <= JOB_DEC;
              state <= S_MLO;
            end else if (bars_seen == p) begin
              job   <= JOB_INIT;
              state <= S_MLO;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_MADD;
        S_MADD: begin
          case (job)
            JOB_DEC:  state <= S_DEC;
            JOB_INIT: state <= S_INIT;
            default:  state <= S_OUT;
          endcase
        end
        S_DEC: begin
          atr   <= atr - dec;
          state <= S_TRADD;
        end
        S_TRADD: begin
          atr   <= add_sat;
          job   <= JOB_OFF;
          state <= S_MLO;
        end
        S_INIT: begin
          atr   <= init_sat;
          job   <= JOB_OFF;
          state <= S_MLO;
        end
        S_OUT: begin
          // hold here until the output register is free
          if (!out_valid || m_axis_tready) begin
            out_long  <= long_sat;
            out_short <= short_sat;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_index)
          ces_pkg::CFG_PERIOD: begin
            // new period restarts warm-up and the window
            period_reg <= cfg_data[ces_pkg::PERIOD_W-1:0];
            atr        <= '0;
            last_close <= '0;
            bars_seen  <= '0;
            state      <= S_IDLE;
          end
          ces_pkg::CFG_MULT:  coef_reg  <= cfg_data[ces_pkg::COEF_W-1:0];
          ces_pkg::CFG_RECIP: recip_reg <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // an accepted bar starts the push step unless a period write comes in the same cycle
  a_accept_push: assert property (@(posedge clk) disable iff (rst)
    (accept && !period_wr) |=> (state == S_PUSH))
    else $error("accepted bar did not start the push step");

  // the bar counter stops at the period
  a_bars_bound: assert property (@(posedge clk) disable iff (rst)
    bars_seen <= p)
    else $error("bar counter ran past the period");

  // no rescan left running once the sequencer is back at idle
  a_idle_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !win_busy)
    else $error("window rescan still running at idle");

  // a result is only built once warm-up is over
  a_out_warm: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (bars_seen == p))
    else $error("result built before warm-up finished");

endmodule

// File: src/ces_mul.sv
// shared multiplier with registered product and a wide accumulator
module ces_mul (
  input  logic                          clk,
  input  ces_pkg::mul_ctrl_t            ctrl,
  input  logic [ces_pkg::MUL_A_W-1:0]   mul_a,
  input  logic [ces_pkg::RECIP_W-1:0]   mul_b,
  output logic [ces_pkg::PROD_W-1:0]    prod,
  output logic [ces_pkg::ACC_W-1:0]     acc
);

  localparam int ACC_W  = ces_pkg::ACC_W;
  localparam int PROD_W = ces_pkg::PROD_W;

  logic [PROD_W-1:0] prod_next;

  assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= prod_next;
    end
    case (ctrl.acc_op)
      ces_pkg::ACC_HOLD:   acc <= acc;
      ces_pkg::ACC_LOAD:   acc <= ACC_W'(prod);
      ces_pkg::ACC_ADD_HI: acc <= acc + (ACC_W'(prod) << ces_pkg::LO_W);
      default:             acc <= acc;
    endcase
  end

endmodule

// File: src/ces_window.sv
// ring store of recent highs and lows with tracked extremes and a sequential rescan
module ces_window #(
  parameter  int WINDOW_MAX = 64,
  localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ces_pkg::win_ctrl_t            ctrl,
  input  logic [SLOT_W:0]               period,
  input  logic [ces_pkg::PRICE_W-1:0]   high,
  input  logic [ces_pkg::PRICE_W-1:0]   low,
  output logic [ces_pkg::PRICE_W-1:0]   max_val,
  output logic [ces_pkg::PRICE_W-1:0]   min_val,
  output logic                          busy
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_MAX - 1);
  localparam logic [SLOT_W:0]   ONE_EXT   = (SLOT_W + 1)'(1);

  logic [ces_pkg::PRICE_W-1:0] high_mem [WINDOW_MAX];
  logic [ces_pkg::PRICE_W-1:0] low_mem  [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]       written;

  logic [SLOT_W-1:0] write_slot, max_slot, min_slot, scan_idx, rd_idx, next_slot;
  logic [SLOT_W:0]   slot_inc;
  logic [ces_pkg::PRICE_W-1:0] rd_high, rd_low, rd_high_eff, rd_low_eff;
  logic scan_act, scan_high, scan_low, rd_v, rd_written, last_issue;

  // ring pointer wraps at the period
  assign slot_inc   = {1'b0, write_slot} + ONE_EXT;
  assign next_slot  = (slot_inc >= period) ? '0 : slot_inc[SLOT_W-1:0];
  assign last_issue = (({1'b0, scan_idx} + ONE_EXT) == period);

  // never-written entries read as zero
  assign rd_high_eff = rd_written ? rd_high : '0;
  assign rd_low_eff  = rd_written ? rd_low  : '0;

  assign busy = scan_act | rd_v;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      high_mem[next_slot] <= high;
      low_mem[next_slot]  <= low;
    end
    rd_high <= high_mem[scan_idx];
    rd_low  <= low_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      written    <= '0;
      write_slot <= LAST_SLOT;
      max_slot   <= '0;
      min_slot   <= '0;
      max_val    <= '0;
      min_val    <= '0;
      scan_act   <= 1'b0;
      scan_high  <= 1'b0;
      scan_low   <= 1'b0;
      scan_idx   <= '0;
      rd_v       <= 1'b0;
      rd_idx     <= '0;
      rd_written <= 1'b0;
    end else begin
      rd_v       <= scan_act;
      rd_idx     <= scan_idx;
      rd_written <= written[scan_idx];

      if (ctrl.push) begin
        written[next_slot] <= 1'b1;
        write_slot         <= next_slot;
        scan_high          <= (max_slot == next_slot);
        scan_low           <= (min_slot == next_slot);
        scan_act           <= (max_slot == next_slot) || (min_slot == next_slot);
        scan_idx           <= '0;
        // new bar takes over the extreme on ties
        if (max_slot != next_slot && max_val <= high) begin
          max_slot <= next_slot;
          max_val  <= high;
        end
        if (min_slot != next_slot && min_val >= low) begin
          min_slot <= next_slot;
          min_val  <= low;
        end
      end else if (scan_act) begin
        if (last_issue) begin
          scan_act <= 1'b0;
        end else begin
          scan_idx <= scan_idx + SLOT_W'(1);
        end
      end

      // rescan: slot zero seeds, later slots win ties
      if (rd_v) begin
        if (scan_high && (rd_idx == '0 || max_val <= rd_high_eff)) begin
          max_val  <= rd_high_eff;
          max_slot <= rd_idx;
        end
        if (scan_low && (rd_idx == '0 || min_val >= rd_low_eff)) begin
          min_val  <= rd_low_eff;
          min_slot <= rd_idx;
        end
      end
    end
  end

endmodule
